// ----- hdl/spq_pkg.sv -----
package spq_pkg;

  localparam int CAPACITY     = 16;
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 16;
  localparam int COUNT_W      = $clog2(CAPACITY + 1);

  // Byte-aligned widths of the packed stream words.
  localparam int IN_DATA_BITS  = KEY_BITS + PAYLOAD_BITS;
  localparam int IN_DATA_W     = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = KEY_BITS + PAYLOAD_BITS + COUNT_W;
  localparam int OUT_DATA_W    = ((OUT_DATA_BITS + 7) / 8) * 8;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]     key;
    logic [PAYLOAD_BITS-1:0] payload;
  } entry_t;

  // Command broadcast to every cell of the row in the cycle a request is taken.
  typedef struct packed {
    logic   insert;
    logic   remove;
    entry_t entry;
  } cell_cmd_t;

endpackage

// ----- hdl/spq_cell.sv -----
module spq_cell
  import spq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  logic      occupied,
  input  logic      left_ge,
  input  entry_t    left_entry,
  input  entry_t    right_entry,
  output logic      ge,
  output entry_t    entry
);

  entry_t entry_next;

  // The new entry belongs at or before this cell when the cell is free or
  // holds a key that is not smaller. Across the sorted row this flag is a
  // thermometer, so the first cell that raises it takes the new entry and
  // every cell after it takes its left neighbor.
  assign ge = !occupied || (entry.key >= cmd.entry.key);

  always_comb begin
    entry_next = entry;
    if (cmd.insert && ge) begin
      entry_next = left_ge ? left_entry : cmd.entry;
    end else if (cmd.remove) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ----- hdl/sorted_priority_queue_core.sv -----
// Sorted priority queue built as a row of CAPACITY cells.
// Requests enter on the s_ channel: s_tuser carries the operation (insert or
// remove) and s_tdata carries the key and payload of an entry to insert.
// Every request produces exactly one result on the m_ channel, carrying the
// removed entry (if any), the entry count after the operation and a status.
// The cells hold the entries in ascending key order. An insert is broadcast
// to all cells at once; each cell compares its key with the new key and
// either keeps its entry, takes the new one, or takes its left neighbor's,
// so an insert or a remove completes at the clock edge that takes the request.
// The result appears in the output register in the cycle after the request
// is taken, and a new request can be taken every cycle as long as the
// result side keeps up. When the receiver stalls with a result pending,
// s_tready is low until that result is taken. Reset clears the entry count
// and the output valid flag; cell contents need no reset because only cells
// below the count are ever read. An insert into a full queue is dropped and
// reported with the full status; a remove on an empty queue reports empty.
module sorted_priority_queue_core
  import spq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // key, payload
  input  logic                  s_tuser,   // operation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // item_key, item_payload, entry_count, zero fill
  output logic [2:0]            m_tuser    // item_valid, status
);

  logic               accept;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  logic               full;
  logic               empty;
  op_t                op;
  cell_cmd_t          cmd;

  logic               ge     [CAPACITY];
  entry_t             cells  [CAPACITY];

  logic               out_item_valid;
  entry_t             out_entry;
  logic [COUNT_W-1:0] out_count;
  status_t            out_status;
  logic               out_item_valid_next;
  entry_t             out_entry_next;
  status_t            out_status_next;

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;
  assign op       = op_t'(s_tuser);
  assign full     = (count == COUNT_W'(CAPACITY));
  assign empty    = (count == '0);

  always_comb begin
    cmd.insert        = accept && (op == OP_INSERT) && !full;
    cmd.remove        = accept && (op == OP_REMOVE) && !empty;
    cmd.entry.key     = s_tdata[KEY_BITS-1:0];
    cmd.entry.payload = s_tdata[KEY_BITS +: PAYLOAD_BITS];
  end

  // The cell row. Cell 0 is the front; the last cell refills with zeros
  // on a remove, which is never read since it is then beyond the count.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ;
    logic   lge;
    entry_t lent;
    entry_t rent;

    assign occ = (count > COUNT_W'(i));

    if (i == 0) begin : g_first
      assign lge  = 1'b0;
      assign lent = '0;
    end else begin : g_mid
      assign lge  = ge[i-1];
      assign lent = cells[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rent = '0;
    end else begin : g_inner
      assign rent = cells[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .cmd         (cmd),
      .occupied    (occ),
      .left_ge     (lge),
      .left_entry  (lent),
      .right_entry (rent),
      .ge          (ge[i]),
      .entry       (cells[i])
    );
  end

  always_comb begin
    count_next          = count;
    out_item_valid_next = 1'b0;
    out_entry_next      = '0;
    out_status_next     = ST_OK;
    if (op == OP_INSERT) begin
      if (full) begin
        out_status_next = ST_FULL;
      end else begin
        count_next = count + COUNT_W'(1);
      end
    end else begin
      if (empty) begin
        out_status_next = ST_EMPTY;
      end else begin
        count_next          = count - COUNT_W'(1);
        out_item_valid_next = 1'b1;
        out_entry_next      = cells[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (accept) begin
        count    <= count_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_valid <= out_item_valid_next;
      out_entry      <= out_entry_next;
      out_count      <= count_next;
      out_status     <= out_status_next;
    end
  end

  assign m_tdata = {{(OUT_DATA_W - OUT_DATA_BITS){1'b0}}, out_count,
                    out_entry.payload, out_entry.key};
  assign m_tuser = {out_status, out_item_valid};

  // The entry count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // A taken insert on a queue with room raises the count by one.
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_INSERT && !full) |=> (count == $past(count) + COUNT_W'(1)))
    else $error("insert did not raise the count");

  // A taken remove on a non-empty queue returns the front entry.
  a_remove_front: assert property (@(posedge clk) disable iff (rst)
    (accept && op == OP_REMOVE && !empty) |=>
      (out_item_valid && out_entry == $past(cells[0]) && out_status == ST_OK))
    else $error("remove did not return the front entry");

  // The two front cells stay in ascending key order.
  a_front_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= COUNT_W'(2)) |-> (cells[0].key <= cells[1].key))
    else $error("front cells out of order");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the sorted priority queue core.
// Each request taken on the s_ channel runs through a shadow copy of the
// sorted store. The shadow copy pushes one expected result into a FIFO, and
// every result taken on the m_ channel is compared field by field with the
// oldest entry of that FIFO.
module tb;
  import spq_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int MAX_PRINTS  = 30;

  // One expected result, in the same field order as the result item.
  typedef struct packed {
    logic                    item_valid;
    logic [KEY_BITS-1:0]     item_key;
    logic [PAYLOAD_BITS-1:0] item_payload;
    logic [COUNT_W-1:0]      entry_count;
    status_t                 status;
  } queue_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // key, payload
  logic                  s_tuser = 1'b0; // operation
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // item_key, item_payload, entry_count, zero fill
  logic [2:0]            m_tuser;        // item_valid, status

  // Shadow of the sorted store, front entry at index 0.
  logic [KEY_BITS-1:0]     shadow_keys [CAPACITY];
  logic [PAYLOAD_BITS-1:0] shadow_payloads [CAPACITY];
  int                      shadow_count = 0;

  queue_result_t pending_results[$];

  // Idle rates in percent, changed by the test tasks between phases.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  int error_count     = 0;
  int cycle_count     = 0;
  int results_checked = 0;
  int inserts_taken   = 0;
  int removes_taken   = 0;
  int full_drops      = 0;
  int empty_removes   = 0;

  sorted_priority_queue_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // The run is stopped here if the block hangs or the receiver starves.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The receiver stalls at random. A rate of zero gives a stall-free stretch.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Prints one line for a mismatch and counts it. Printing stops after a
  // while so that a badly broken block does not flood the log.
  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("mismatch at result %0d: %s got %0h want %0h",
               results_checked, what, got, want);
    end
  endtask

  // Applies one request to the shadow store and returns the result that the
  // block must give for it. Inserts go in front of the first entry whose key
  // is not smaller, so the newest of several equal keys is served first.
  function automatic queue_result_t predict_queue_result(op_t op,
                                                         logic [KEY_BITS-1:0] key,
                                                         logic [PAYLOAD_BITS-1:0] payload);
    queue_result_t r;
    int            pos;
    r = '0;
    r.status = ST_OK;
    if (op == OP_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        // A full queue drops the entry and leaves the store as it was.
        r.status = ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] < key) pos++;
        for (int i = shadow_count; i > pos; i--) begin
          shadow_keys[i]     = shadow_keys[i-1];
          shadow_payloads[i] = shadow_payloads[i-1];
        end
        shadow_keys[pos]     = key;
        shadow_payloads[pos] = payload;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      // Remove on an empty queue returns no entry.
      r.status = ST_EMPTY;
    end else begin
      r.item_valid   = 1'b1;
      r.item_key     = shadow_keys[0];
      r.item_payload = shadow_payloads[0];
      for (int i = 1; i < shadow_count; i++) begin
        shadow_keys[i-1]     = shadow_keys[i];
        shadow_payloads[i-1] = shadow_payloads[i];
      end
      shadow_count--;
    end
    r.entry_count = COUNT_W'(shadow_count);
    return r;
  endfunction

  // Both channels are sampled at the rising edge, so every value seen here
  // is the one that stood before the edge. The result side is checked before
  // the request side is predicted; a result can never belong to a request
  // taken at the same edge since the block registers every result.
  always @(posedge clk) begin : result_check
    queue_result_t want;
    queue_result_t req_result;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result, tdata", m_tdata[31:0], '0);
        end else begin
          want = pending_results.pop_front();
          if (m_tuser[0] !== want.item_valid)
            report_mismatch("item_valid", 32'(m_tuser[0]), 32'(want.item_valid));
          if (m_tdata[KEY_BITS-1:0] !== want.item_key)
            report_mismatch("item_key", 32'(m_tdata[KEY_BITS-1:0]), 32'(want.item_key));
          if (m_tdata[KEY_BITS +: PAYLOAD_BITS] !== want.item_payload)
            report_mismatch("item_payload", 32'(m_tdata[KEY_BITS +: PAYLOAD_BITS]),
                            32'(want.item_payload));
          if (m_tdata[KEY_BITS+PAYLOAD_BITS +: COUNT_W] !== want.entry_count)
            report_mismatch("entry_count", 32'(m_tdata[KEY_BITS+PAYLOAD_BITS +: COUNT_W]),
                            32'(want.entry_count));
          if (m_tuser[2:1] !== want.status)
            report_mismatch("status", 32'(m_tuser[2:1]), 32'(want.status));
          if ((m_tdata >> OUT_DATA_BITS) !== '0)
            report_mismatch("zero fill", 32'(m_tdata >> OUT_DATA_BITS), '0);
          results_checked++;
        end
      end
      if (s_tvalid && s_tready) begin
        req_result = predict_queue_result(op_t'(s_tuser), s_tdata[KEY_BITS-1:0],
                                          s_tdata[KEY_BITS +: PAYLOAD_BITS]);
        pending_results.push_back(req_result);
        if (op_t'(s_tuser) == OP_INSERT) inserts_taken++;
        else removes_taken++;
        if (req_result.status == ST_FULL) full_drops++;
        if (req_result.status == ST_EMPTY) empty_removes++;
      end
    end
  end

  // Offers one request and waits until it is taken. It must be called right
  // after a rising edge. The valid flag stays high into the next request
  // unless an idle gap is drawn, so back-to-back requests need no toggling.
  task automatic send_request(op_t op, logic [KEY_BITS-1:0] key,
                              logic [PAYLOAD_BITS-1:0] payload);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= IN_DATA_W'({payload, key});
    do @(posedge clk); while (!s_tready);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // The first request after reset is a remove, which must report empty.
  // Nonzero key and payload bits check that a remove ignores them.
  task automatic test_remove_on_empty();
    send_request(OP_REMOVE, '1, '1);
  endtask

  // The largest and smallest keys with extreme payloads, then two equal keys
  // whose order must come out newest first.
  task automatic test_extremes_and_ties();
    send_request(OP_INSERT, 16'hFFFF, 16'h0000);
    send_request(OP_INSERT, 16'h0000, 16'hFFFF);
    send_request(OP_INSERT, 16'h1234, 16'h0001);
    send_request(OP_INSERT, 16'h1234, 16'h0002);
  endtask

  // Fills the rest of the queue, then inserts once more, which must be
  // dropped with the full status. The first fill key ties with the zero key
  // inserted before it.
  task automatic test_insert_when_full();
    for (int i = 0; i < CAPACITY - 4; i++) begin
      send_request(OP_INSERT, KEY_BITS'(16'h1000 * i), PAYLOAD_BITS'(16'hA5A5 ^ i));
    end
    send_request(OP_INSERT, 16'h0001, 16'hAAAA);
  endtask

  // Takes four entries from the front of the full queue.
  task automatic test_front_removal();
    repeat (4) send_request(OP_REMOVE, '0, '0);
  endtask

  // Random traffic in bursts that lean toward filling, draining or neither,
  // so the queue keeps running into the full and the empty boundary. Keys
  // are drawn from the full range, from a narrow range that makes ties
  // common, and from the two extremes.
  task automatic test_random_traffic(int send_pct, int stall_pct, int items);
    int   insert_pct;
    op_t  op;
    logic [KEY_BITS-1:0] key;
    insert_pct     = 50;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < items; n++) begin
      if (n % 24 == 0) begin
        case ($urandom_range(2))
          0:       insert_pct = 85;
          1:       insert_pct = 15;
          default: insert_pct = 50;
        endcase
      end
      op = ($urandom_range(99) < insert_pct) ? OP_INSERT : OP_REMOVE;
      case ($urandom_range(3))
        0:       key = KEY_BITS'($urandom_range(7));
        1:       key = $urandom_range(1) ? '1 : '0;
        default: key = KEY_BITS'($urandom);
      endcase
      send_request(op, key, PAYLOAD_BITS'($urandom));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part, with neither side idling.
    test_remove_on_empty();
    test_extremes_and_ties();
    test_insert_when_full();
    test_front_removal();

    // Random part, one phase per idling pattern.
    test_random_traffic(0, 0, 220);
    test_random_traffic(83, 0, 220);
    test_random_traffic(0, 83, 220);
    test_random_traffic(24, 24, 220);

    // Drain every outstanding result, then let the pipeline settle so a
    // late spurious result is still caught.
    s_tvalid       <= 1'b0;
    recv_stall_pct = 0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);

    $display("checked %0d results: %0d inserts (%0d dropped full), %0d removes (%0d on empty)",
             results_checked, inserts_taken, full_drops, removes_taken, empty_removes);
    $display("phases covered no idling, sender idle, receiver stall and both idling");
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches, %0d results missing", error_count, pending_results.size());
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/spq_pkg.sv
hdl/spq_cell.sv
hdl/sorted_priority_queue_core.sv
bench/tb.sv
